// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SETUP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

    localparam logic [7:0] HALF_BIT_RESET = 8'd2;
    localparam logic [7:0] EDGE_SETUP_RESET = 8'd4;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_WAIT  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       ack_missing;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       ready_res;
        logic       sda_pull_low;
        logic       scl_level;
    } result_t;

endpackage

// ===== rtl/i2cm_front.sv =====
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic [S_DATA_W-1:0] s_tdata,
    output item_t               item
);

    logic [2:0] action;

    assign action = s_tdata[2:0];

    always_comb begin
        item.tx_byte  = s_tdata[10:3];
        item.send_ack = s_tdata[11];
        item.sda_in   = s_tdata[12];
        case (action)
            CMD_START: item.cmd = CMD_START;
            CMD_STOP:  item.cmd = CMD_STOP;
            CMD_WRITE: item.cmd = CMD_WRITE;
            CMD_WAIT:  item.cmd = CMD_WAIT;
            CMD_READ:  item.cmd = CMD_READ;
            default:   item.cmd = CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/i2cm_queue.sv =====
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/i2cm_back.sv =====
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata
);

    typedef enum logic [12:0] {
        PH_IDLE  = 13'b0000000000001,
        PH_ST_A  = 13'b0000000000010,
        PH_ST_B  = 13'b0000000000100,
        PH_SP_A  = 13'b0000000001000,
        PH_SP_B  = 13'b0000000010000,
        PH_WR_LO = 13'b0000000100000,
        PH_WR_HI = 13'b0000001000000,
        PH_WA_LO = 13'b0000010000000,
        PH_WA_HI = 13'b0000100000000,
        PH_RD_LO = 13'b0001000000000,
        PH_RD_HI = 13'b0010000000000,
        PH_RA_LO = 13'b0100000000000,
        PH_RA_HI = 13'b1000000000000
    } phase_t;

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    logic [7:0] half_bit_reg, edge_setup_reg, ack_timeout_reg;

    phase_t     phase_reg, phase_next;
    logic       is_wait_reg, is_wait_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] ack_wait_reg, ack_wait_next;
    logic       ack_to_send_reg, ack_to_send_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    logic       miss_reg, miss_next;
    logic       ready_res, done_res;

    logic       m_tvalid_reg, m_tvalid_next;
    result_t    m_result_reg;
    result_t    result;
    logic       fire;
    logic [7:0] h_ticks, e_ticks;
    logic [3:0] bit_index_inc;
    logic [7:0] shift_wr, shift_rd;

    assign item_ready    = !m_tvalid_reg || m_tready;
    assign fire          = item_valid && item_ready;
    assign h_ticks       = at_least_one(half_bit_reg);
    assign e_ticks       = at_least_one(edge_setup_reg);
    assign bit_index_inc = bit_index_reg + 4'd1;
    assign shift_wr      = {shift_reg[6:0], 1'b0};
    assign shift_rd      = {shift_reg[6:0], item.sda_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_bit_reg    <= HALF_BIT_RESET;
            edge_setup_reg  <= EDGE_SETUP_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HALF_BIT:    half_bit_reg    <= cfg_wdata;
                CFG_EDGE_SETUP:  edge_setup_reg  <= cfg_wdata;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        is_wait_next     = is_wait_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        tick_next        = tick_reg;
        ack_wait_next    = ack_wait_reg;
        ack_to_send_next = ack_to_send_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        rx_hold_next     = rx_hold_reg;
        miss_next        = miss_reg;
        ready_res        = 1'b0;
        done_res         = 1'b0;
        if (fire) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (item.cmd != CMD_NONE) begin
                        ready_res      = 1'b1;
                        miss_next      = 1'b0;
                        is_wait_next   = (item.cmd == CMD_WAIT);
                        bit_index_next = 4'd0;
                        case (item.cmd)
                            CMD_START: begin
                                phase_next = PH_ST_A;
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                tick_next  = e_ticks;
                            end
                            CMD_STOP: begin
                                phase_next = PH_SP_A;
                                scl_next   = 1'b0;
                                sda_next   = 1'b0;
                                tick_next  = e_ticks;
                            end
                            CMD_WRITE: begin
                                shift_next = item.tx_byte;
                                phase_next = PH_WR_LO;
                                scl_next   = 1'b0;
                                sda_next   = item.tx_byte[7];
                                tick_next  = h_ticks;
                            end
                            CMD_WAIT: begin
                                ack_wait_next = 8'd0;
                                phase_next    = PH_WA_LO;
                                scl_next      = 1'b0;
                                sda_next      = 1'b1;
                                tick_next     = h_ticks;
                            end
                            default: begin
                                shift_next       = 8'd0;
                                ack_to_send_next = item.send_ack;
                                phase_next       = PH_RD_LO;
                                scl_next         = 1'b0;
                                sda_next         = 1'b1;
                                tick_next        = h_ticks;
                            end
                        endcase
                    end
                end
                PH_WA_HI: begin
                    if (!item.sda_in) begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_res   = 1'b1;
                    end else if (ack_wait_reg >= at_least_one(ack_timeout_reg)) begin
                        phase_next = PH_SP_A;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        tick_next  = e_ticks;
                    end else begin
                        ack_wait_next = ack_wait_reg + 8'd1;
                    end
                end
                default: begin
                    if (tick_reg > 8'd1) begin
                        tick_next = tick_reg - 8'd1;
                    end else begin
                        case (phase_reg)
                            PH_ST_A: begin
                                phase_next = PH_ST_B;
                                scl_next   = 1'b1;
                                sda_next   = 1'b0;
                                tick_next  = e_ticks;
                            end
                            PH_ST_B: begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done_res   = 1'b1;
                            end
                            PH_SP_A: begin
                                phase_next = PH_SP_B;
                                scl_next   = 1'b1;
                                sda_next   = 1'b0;
                                tick_next  = e_ticks;
                            end
                            PH_SP_B: begin
                                sda_next   = 1'b1;
                                miss_next  = miss_reg | is_wait_reg;
                                phase_next = PH_IDLE;
                                done_res   = 1'b1;
                            end
                            PH_WR_LO: begin
                                phase_next = PH_WR_HI;
                                scl_next   = 1'b1;
                                tick_next  = h_ticks;
                            end
                            PH_WR_HI: begin
                                bit_index_next = bit_index_inc;
                                shift_next     = shift_wr;
                                if (bit_index_inc < BITS_PER_BYTE) begin
                                    phase_next = PH_WR_LO;
                                    scl_next   = 1'b0;
                                    sda_next   = shift_wr[7];
                                    tick_next  = h_ticks;
                                end else begin
                                    scl_next   = 1'b0;
                                    sda_next   = 1'b1;
                                    phase_next = PH_IDLE;
                                    done_res   = 1'b1;
                                end
                            end
                            PH_WA_LO: begin
                                phase_next = PH_WA_HI;
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                tick_next  = 8'd1;
                            end
                            PH_RD_LO: begin
                                phase_next = PH_RD_HI;
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                tick_next  = h_ticks;
                            end
                            PH_RD_HI: begin
                                shift_next     = shift_rd;
                                bit_index_next = bit_index_inc;
                                scl_next       = 1'b0;
                                tick_next      = h_ticks;
                                if (bit_index_inc < BITS_PER_BYTE) begin
                                    phase_next = PH_RD_LO;
                                    sda_next   = 1'b1;
                                end else begin
                                    phase_next = PH_RA_LO;
                                    sda_next   = !ack_to_send_reg;
                                end
                            end
                            PH_RA_LO: begin
                                phase_next = PH_RA_HI;
                                scl_next   = 1'b1;
                                tick_next  = h_ticks;
                            end
                            PH_RA_HI: begin
                                scl_next     = 1'b0;
                                sda_next     = 1'b1;
                                rx_hold_next = shift_reg;
                                phase_next   = PH_IDLE;
                                done_res     = 1'b1;
                            end
                            default: begin
                                phase_next = PH_IDLE;
                                done_res   = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.scl_level    = scl_next;
        result.sda_pull_low = !sda_next;
        result.ready_res    = ready_res;
        result.done_res     = done_res;
        result.rx_byte      = rx_hold_next;
        result.ack_missing  = miss_next;
        m_tvalid_next       = fire || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            is_wait_reg     <= 1'b0;
            bit_index_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            tick_reg        <= 8'd0;
            ack_wait_reg    <= 8'd0;
            ack_to_send_reg <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            rx_hold_reg     <= 8'd0;
            miss_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            is_wait_reg     <= is_wait_next;
            bit_index_reg   <= bit_index_next;
            shift_reg       <= shift_next;
            tick_reg        <= tick_next;
            ack_wait_reg    <= ack_wait_next;
            ack_to_send_reg <= ack_to_send_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            rx_hold_reg     <= rx_hold_next;
            miss_reg        <= miss_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_result_reg);

endmodule

// ===== rtl/i2c_master_bit_engine_top.sv =====
// Path: a transfer accepted on s_ is held in a queue entry, then passes the bit engine and
// the output register after it before it appears on m_.
// Throughput: one tick per cycle while the queue holds an item and the output is not stalled.
// Reset (aresetn, synchronous, active low): queue and output empty, SCL and SDA released
// high, registers back to half bit 2, edge setup 4, ack timeout 250.
module i2c_master_bit_engine_top
    import i2cm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // action[2:0], tx_byte[10:3], send_ack[11], sda_in[12]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // scl_level[0], sda_pull_low[1], ready_res[2],
                                             // done_res[3], rx_byte[11:4], ack_missing[12]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    i2cm_front u_front (
        .s_tdata (s_tdata),
        .item    (in_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (in_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    i2cm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTH
    a_ready_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("ready and done in one result");

    a_engine_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> m_tvalid)
        else $error("queued tick did not reach output");

    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !q_ready)
        else $error("engine advanced while output stalled");
`endif

endmodule
